FILE: src/lla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lla_pkg
// Shared types and constants for the life-like automaton generation block.
// ----------------------------------------------------------------------------
package lla_pkg;

  localparam int ROW_BITS       = 64;
  localparam int RULE_BITS      = 9;
  localparam int CFG_INDEX_BITS = 1;

  typedef logic [ROW_BITS-1:0]       row_t;
  typedef logic [RULE_BITS-1:0]      rule_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_BIRTH_MASK   = 1'd0;
  localparam cfg_index_t REG_SURVIVE_MASK = 1'd1;

  localparam rule_t BIRTH_MASK_RESET   = 9'd8;
  localparam rule_t SURVIVE_MASK_RESET = 9'd12;

endpackage

`default_nettype wire

FILE: src/lla_evolve.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lla_evolve
// Next generation of one row from the rows above and below, all cells in
// parallel; cells outside the grid count as dead.
// ----------------------------------------------------------------------------
module lla_evolve #(
  parameter int GRID_WIDTH = 64
) (
  input  wire logic [GRID_WIDTH-1:0] above,
  input  wire logic [GRID_WIDTH-1:0] mid,
  input  wire logic [GRID_WIDTH-1:0] below,
  input  wire lla_pkg::rule_t        birth_mask,
  input  wire lla_pkg::rule_t        survive_mask,
  output logic [GRID_WIDTH-1:0]      next_row
);

  logic [GRID_WIDTH+1:0] pad_above;
  logic [GRID_WIDTH+1:0] pad_mid;
  logic [GRID_WIDTH+1:0] pad_below;

  assign pad_above = {1'b0, above, 1'b0};
  assign pad_mid   = {1'b0, mid, 1'b0};
  assign pad_below = {1'b0, below, 1'b0};

  for (genvar k = 0; k < GRID_WIDTH; k++) begin : g_cell
    logic [3:0]     count;
    lla_pkg::rule_t rule;

    assign count = {3'b000, pad_above[k]} + {3'b000, pad_above[k+1]}
                 + {3'b000, pad_above[k+2]} + {3'b000, pad_mid[k]}
                 + {3'b000, pad_mid[k+2]} + {3'b000, pad_below[k]}
                 + {3'b000, pad_below[k+1]} + {3'b000, pad_below[k+2]};
    assign rule = mid[k] ? survive_mask : birth_mask;
    assign next_row[k] = rule[count];
  end

endmodule

`default_nettype wire

FILE: src/life_like_automaton_generation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// life_like_automaton_generation
// One generation of a life-like cellular automaton, streamed one row per
// transaction.
//
// Input channel (in_valid/in_ready) carries a grid row, top row first, with
// is_last_row on the final row of the frame. Output channel
// (out_valid/out_ready) returns next-generation rows, last_of_frame on the
// final one. Each row is emitted one row behind its input; the first row of
// a frame gives no result, the last row gives two (a one-row frame gives one).
// out_valid rises once the row that completes the neighborhood has passed the
// input register and the result register; a flush step then gives the second
// result of a last row. Throughput: one row per cycle while the receiver does
// not stall, set by the single evolve unit; a last row adds a flush step.
// birth_mask and survive_mask are written through cfg_we/cfg_index/cfg_data,
// by the user only while the block is idle; the block does not enforce this.
// Reset clears the row buffers and returns the masks to 8 and 12.
// When the receiver stalls the result register holds; one more row is taken
// into the input register, then in_ready drops.
// ----------------------------------------------------------------------------
module life_like_automaton_generation #(
  parameter int GRID_WIDTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire lla_pkg::row_t         row_cells,
  input  wire logic                  is_last_row,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output lla_pkg::row_t              next_row_cells,
  output logic                       last_of_frame,
  input  wire logic                  cfg_we,
  input  wire lla_pkg::cfg_index_t   cfg_index,
  input  wire lla_pkg::rule_t        cfg_data
);

  lla_pkg::rule_t        birth_mask;
  lla_pkg::rule_t        survive_mask;

  logic                  s1_valid;
  logic [GRID_WIDTH-1:0] s1_row;
  logic                  s1_last;

  logic [GRID_WIDTH-1:0] upper_row;
  logic [GRID_WIDTH-1:0] middle_row;
  logic [1:0]            rows_held;
  logic                  flush_pending;

  logic                  empty_frame;
  logic                  need_out;
  logic                  out_free;
  logic                  step;
  logic                  consume;
  logic                  frame_done;
  logic                  result_last;

  logic [GRID_WIDTH-1:0] evo_above;
  logic [GRID_WIDTH-1:0] evo_mid;
  logic [GRID_WIDTH-1:0] evo_below;
  logic [GRID_WIDTH-1:0] evo_row;

  assign empty_frame = (rows_held == 2'd0);
  assign need_out    = flush_pending || !empty_frame || s1_last;
  assign out_free    = !out_valid || out_ready;
  assign step        = s1_valid && (!need_out || out_free);
  assign consume     = step && !(!empty_frame && !flush_pending && s1_last);
  assign in_ready    = !s1_valid || consume;
  assign frame_done  = flush_pending || (empty_frame && s1_last);
  assign result_last = frame_done;

  always_comb begin
    if (flush_pending) begin
      evo_above = upper_row;
      evo_mid   = middle_row;
      evo_below = '0;
    end else if (empty_frame) begin
      evo_above = '0;
      evo_mid   = s1_row;
      evo_below = '0;
    end else begin
      evo_above = upper_row;
      evo_mid   = middle_row;
      evo_below = s1_row;
    end
  end

  lla_evolve #(
    .GRID_WIDTH(GRID_WIDTH)
  ) u_evolve (
    .above       (evo_above),
    .mid         (evo_mid),
    .below       (evo_below),
    .birth_mask  (birth_mask),
    .survive_mask(survive_mask),
    .next_row    (evo_row)
  );

  // rule registers
  always_ff @(posedge clk) begin
    if (rst) begin
      birth_mask   <= lla_pkg::BIRTH_MASK_RESET;
      survive_mask <= lla_pkg::SURVIVE_MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lla_pkg::REG_BIRTH_MASK:   birth_mask   <= cfg_data;
        lla_pkg::REG_SURVIVE_MASK: survive_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (consume) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_row  <= row_cells[GRID_WIDTH-1:0];
      s1_last <= is_last_row;
    end
  end

  // row buffers
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row     <= '0;
      middle_row    <= '0;
      rows_held     <= 2'd0;
      flush_pending <= 1'b0;
    end else if (step) begin
      if (frame_done) begin
        upper_row     <= '0;
        middle_row    <= '0;
        rows_held     <= 2'd0;
        flush_pending <= 1'b0;
      end else if (empty_frame) begin
        upper_row  <= '0;
        middle_row <= s1_row;
        rows_held  <= 2'd1;
      end else begin
        upper_row     <= middle_row;
        middle_row    <= s1_row;
        rows_held     <= 2'd2;
        flush_pending <= s1_last;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && need_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && need_out) begin
      next_row_cells <= lla_pkg::row_t'(evo_row);
      last_of_frame  <= result_last;
    end
  end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for life_like_automaton_generation. Grid frames are
// streamed one row per transaction under several birth/survival rules,
// including the empty and the full rule. A scoreboard keeps its own copy of
// the row buffers and rules, computes each next-generation row, and compares
// every returned row and end-of-frame flag in order. Both handshake sides
// idle in random bursts, except over the final stretch of the run.
// ----------------------------------------------------------------------------
module testbench;

  localparam int GRID_WIDTH     = 64;
  localparam int WATCHDOG_LIMIT = 200;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct {
    lla_pkg::row_t cells;
    logic          last;
  } gen_row_t;

  class life_scoreboard;
    lla_pkg::rule_t birth_mask;
    lla_pkg::rule_t survive_mask;
    lla_pkg::row_t  upper;
    lla_pkg::row_t  middle;
    bit             frame_open;
    gen_row_t       expected_rows[$];
    int             mismatches;

    function new();
      birth_mask   = lla_pkg::BIRTH_MASK_RESET;
      survive_mask = lla_pkg::SURVIVE_MASK_RESET;
      upper        = '0;
      middle       = '0;
      frame_open   = 0;
      mismatches   = 0;
    endfunction

    function void set_rule(lla_pkg::cfg_index_t idx, lla_pkg::rule_t val);
      if (idx == lla_pkg::REG_BIRTH_MASK) begin
        birth_mask = val;
      end else if (idx == lla_pkg::REG_SURVIVE_MASK) begin
        survive_mask = val;
      end
    endfunction

    function lla_pkg::row_t width_mask();
      if (GRID_WIDTH >= 64) begin
        return '1;
      end
      return (lla_pkg::row_t'(1) << GRID_WIDTH) - 1;
    endfunction

    function lla_pkg::row_t next_gen(lla_pkg::row_t above, lla_pkg::row_t mid,
                                     lla_pkg::row_t below);
      lla_pkg::row_t  res;
      int             n_live;
      lla_pkg::rule_t keep_mask;
      res = '0;
      for (int k = 0; k < GRID_WIDTH; k++) begin
        n_live = above[k] + below[k];
        if (k > 0) begin
          n_live += above[k-1] + mid[k-1] + below[k-1];
        end
        if (k < 63) begin
          n_live += above[k+1] + mid[k+1] + below[k+1];
        end
        keep_mask = mid[k] ? survive_mask : birth_mask;
        res[k] = keep_mask[n_live];
      end
      return res & width_mask();
    endfunction

    function void note_row(lla_pkg::row_t row_in, logic last);
      lla_pkg::row_t row;
      gen_row_t      e;
      row = row_in & width_mask();
      if (!frame_open) begin
        upper      = '0;
        middle     = row;
        frame_open = 1;
      end else begin
        e.cells = next_gen(upper, middle, row);
        e.last  = 1'b0;
        expected_rows.push_back(e);
        upper  = middle;
        middle = row;
      end
      if (last) begin
        e.cells = next_gen(upper, middle, '0);
        e.last  = 1'b1;
        expected_rows.push_back(e);
        upper      = '0;
        middle     = '0;
        frame_open = 0;
      end
    endfunction

    function void check_result(lla_pkg::row_t cells, logic last);
      gen_row_t e;
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected transaction: row %h last %b", cells, last);
        end
        return;
      end
      e = expected_rows.pop_front();
      if (cells !== e.cells) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("next_row_cells: expected %h, got %h", e.cells, cells);
        end
      end
      if (last !== e.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("last_of_frame: expected %b, got %b", e.last, last);
        end
      end
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  lla_pkg::row_t       row_cells;
  logic                is_last_row;
  logic                out_valid;
  logic                out_ready;
  lla_pkg::row_t       next_row_cells;
  logic                last_of_frame;
  logic                cfg_we;
  lla_pkg::cfg_index_t cfg_index;
  lla_pkg::rule_t      cfg_data;

  bit             quiet = 0;
  int             idle_cycles = 0;
  life_scoreboard gen_board = new();

  life_like_automaton_generation #(
    .GRID_WIDTH(GRID_WIDTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .row_cells     (row_cells),
    .is_last_row   (is_last_row),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .next_row_cells(next_row_cells),
    .last_of_frame (last_of_frame),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver with random stall bursts
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (quiet || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      gen_board.check_result(next_row_cells, last_of_frame);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic lla_pkg::row_t rand_row();
    lla_pkg::row_t r;
    case ($urandom_range(0, 9))
      0: r = '0;
      1: r = '1;
      2: r = lla_pkg::row_t'(1) << $urandom_range(0, 63);
      3, 4, 5: r = {$urandom(), $urandom()};
      6, 7: r = {$urandom(), $urandom()} & {$urandom(), $urandom()} & {$urandom(), $urandom()};
      8: r = lla_pkg::row_t'($urandom_range(1, 255)) << $urandom_range(0, 56);
      default: r = ~({$urandom(), $urandom()} & {$urandom(), $urandom()});
    endcase
    return r;
  endfunction

  task automatic send_row(lla_pkg::row_t cells, logic last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    row_cells   <= cells;
    is_last_row <= last;
    do @(posedge clk); while (!in_ready);
    gen_board.note_row(cells, last);
  endtask

  task automatic send_frame(int rows);
    for (int i = 0; i < rows; i++) begin
      send_row(rand_row(), i == rows - 1);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (gen_board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_rules(lla_pkg::rule_t birth, lla_pkg::rule_t survive);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= lla_pkg::REG_BIRTH_MASK;
    cfg_data  <= birth;
    @(posedge clk);
    cfg_index <= lla_pkg::REG_SURVIVE_MASK;
    cfg_data  <= survive;
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_board.set_rule(lla_pkg::REG_BIRTH_MASK, birth);
    gen_board.set_rule(lla_pkg::REG_SURVIVE_MASK, survive);
  endtask

  initial begin
    int             phase_rows;
    int             height;
    lla_pkg::rule_t birth;
    lla_pkg::rule_t survive;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    row_cells   <= '0;
    is_last_row <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= lla_pkg::REG_BIRTH_MASK;
    cfg_data    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset rule: single-row frames, blinker, edge cells, full grid
    send_row('0, 1'b1);
    send_row('1, 1'b1);
    send_row(64'h20, 1'b0);
    send_row(64'h20, 1'b0);
    send_row(64'h20, 1'b1);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row(64'hc000_0000_0000_0003, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b1);
    send_row('1, 1'b0);
    send_row('1, 1'b1);

    // empty and full rules, and their two mixes
    set_rules('0, '0);
    send_frame(3);
    set_rules('1, '1);
    send_frame(3);
    set_rules('1, '0);
    send_frame(3);
    set_rules('0, '1);
    send_frame(3);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        1: begin
          birth   = 9'd8;
          survive = 9'd12;
        end
        2: begin
          birth   = 9'd72;
          survive = 9'd12;
        end
        default: begin
          birth   = lla_pkg::rule_t'($urandom_range(0, 511));
          survive = lla_pkg::rule_t'($urandom_range(0, 511));
        end
      endcase
      if (phase == 7) begin
        quiet = 1;
      end
      set_rules(birth, survive);
      phase_rows = 0;
      while (phase_rows < 62) begin
        height = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        send_frame(height);
        phase_rows += height;
      end
    end

    settle();
    if (gen_board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/lla_pkg.sv
src/lla_evolve.sv
src/life_like_automaton_generation.sv
sim/testbench.sv
